FILE: rtl/core/drd_pkg.sv
// Package for the distinct random draw block.
// Holds sizes, register indexes and command codes; no dependencies.
package drd_pkg;

  localparam int POOL_DEPTH  = 256;
  localparam int RANDOM_BITS = 31;

  localparam int VALUE_W    = 32;
  localparam int SIZE_W     = 9;
  localparam int RWORD_W    = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int IDX_W   = $clog2(POOL_DEPTH);
  localparam int CNT_W   = $clog2(POOL_DEPTH + 1);
  localparam int RW_USED = (RANDOM_BITS < RWORD_W) ? RANDOM_BITS : RWORD_W;
  localparam int STEP_W  = $clog2(RW_USED + 1);

  localparam logic [CNT_W-1:0] POOL_FULL = CNT_W'(POOL_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_START_VALUE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_COUNT  = 2'd2;

  localparam logic CMD_DRAW    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

endpackage

FILE: rtl/core/drd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module drd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/drd_mod_serial.sv
// Bit-serial restoring modulo: dividend mod divisor, one dividend bit per cycle.
// Depends on drd_pkg.
module drd_mod_serial (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [drd_pkg::RW_USED-1:0] dividend,
  input  logic [drd_pkg::CNT_W-1:0]   divisor,
  output logic                        done,
  output logic [drd_pkg::IDX_W-1:0]   remainder
);
  import drd_pkg::*;

  logic [RW_USED-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;
  logic               run_r, run_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W:0]     trial;

  assign trial = {rem_r, shift_r[RW_USED-1]};

  always_comb begin
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    if (go) begin
      shift_nxt = dividend;
      rem_nxt   = '0;
      cnt_nxt   = STEP_W'(RW_USED);
      run_nxt   = 1'b1;
    end else if (run_r) begin
      shift_nxt = {shift_r[RW_USED-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = CNT_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = CNT_W'(trial);
      end
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r[IDX_W-1:0];

endmodule

FILE: rtl/core/distinct_random_draw_from_range.sv
// Distinct random draw from a range: top level.
// Depends on drd_pkg, drd_mod_serial, drd_ram.
//
// Usage:
//   Command channel: a request (in_cmd, in_random_word) is taken at a clock
//   edge with start high and busy low. in_cmd draw picks one unused value of
//   start_value .. start_value+min(pool_size,256)-1; in_cmd restart refills the pool.
//   Every request gives exactly one result, shown for one cycle with
//   out_valid high; the receiver cannot stall it.
//   Restart and rejected draws (empty pool, draws used up): result in the
//   cycle after the request, busy stays low, so one such request per cycle.
//   Accepted draws: the result follows the bit-serial modulo (one random bit
//   per cycle) and then two reads and one write of the offset RAM (registered
//   read). busy is high until then; the next request is taken with the result.
//   Config channel: cfg_index/cfg_wdata taken when cfg_valid is high
//   (cfg_ready is always high); write only while busy is low and no result
//   is pending. pool_size takes effect at the next restart.
//   Reset: registers go to start_value 1, pool_size 256, draw_count 256 and
//   the pool is full; no clearing pass is needed.
module distinct_random_draw_from_range (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_cmd,
  input  logic [drd_pkg::RWORD_W-1:0]    in_random_word,
  output logic                           out_valid,
  output logic signed [drd_pkg::VALUE_W-1:0] out_drawn_value,
  output logic [drd_pkg::SIZE_W-1:0]     out_values_left,
  output logic                           out_draw_error,
  output logic                           out_last_draw,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [drd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import drd_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DIV     = 3'd1;
  localparam logic [2:0] S_RD_PICK = 3'd2;
  localparam logic [2:0] S_RD_TAIL = 3'd3;
  localparam logic [2:0] S_WRITE   = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [VALUE_W-1:0]  start_value_r;
  logic [SIZE_W-1:0]   pool_size_r;
  logic [SIZE_W-1:0]   draw_count_r;
  logic [CNT_W-1:0]    live_r, live_nxt;
  logic [CNT_W-1:0]    draws_r, draws_nxt;
  logic [POOL_DEPTH-1:0] written_r, written_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    picked_r, picked_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  drawn_r, drawn_nxt;
  logic [CNT_W-1:0]    left_r, left_nxt;
  logic                err_r, err_nxt;
  logic                last_r, last_nxt;

  logic                accept;
  logic                no_draw;
  logic                div_go;
  logic                div_done;
  logic [IDX_W-1:0]    div_rem;
  logic [CNT_W-1:0]    clamp_size;
  logic [IDX_W-1:0]    tail;
  logic [IDX_W-1:0]    moved;
  logic [CNT_W-1:0]    draws_inc;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_raddr;
  logic [IDX_W-1:0]    ram_rdata;

  assign accept     = start && (state_r == S_IDLE);
  assign no_draw    = (live_r == '0) || (32'(draws_r) >= 32'(draw_count_r));
  assign div_go     = accept && (in_cmd == CMD_DRAW) && !no_draw;
  assign clamp_size = (32'(pool_size_r) > 32'(POOL_DEPTH)) ? POOL_FULL
                                                            : CNT_W'(pool_size_r);
  assign tail       = IDX_W'(live_r - CNT_W'(1));
  assign moved      = written_r[tail] ? ram_rdata : tail;
  assign draws_inc  = draws_r + CNT_W'(1);
  assign ram_we     = (state_r == S_WRITE);
  assign ram_raddr  = (state_r == S_RD_TAIL) ? tail : idx_r;

  drd_mod_serial u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go),
    .dividend  (in_random_word[RW_USED-1:0]),
    .divisor   (live_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  drd_ram #(
    .WIDTH (IDX_W),
    .DEPTH (POOL_DEPTH)
  ) u_pool (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (moved),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    live_nxt      = live_r;
    draws_nxt     = draws_r;
    written_nxt   = written_r;
    idx_nxt       = idx_r;
    picked_nxt    = picked_r;
    out_valid_nxt = 1'b0;
    drawn_nxt     = drawn_r;
    left_nxt      = left_r;
    err_nxt       = err_r;
    last_nxt      = last_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_RESTART) begin
            written_nxt   = '0;
            live_nxt      = clamp_size;
            draws_nxt     = '0;
            out_valid_nxt = 1'b1;
            drawn_nxt     = '0;
            left_nxt      = clamp_size;
            err_nxt       = 1'b0;
            last_nxt      = 1'b0;
          end else if (no_draw) begin
            out_valid_nxt = 1'b1;
            drawn_nxt     = '0;
            left_nxt      = live_r;
            err_nxt       = 1'b1;
            last_nxt      = 1'b0;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          idx_nxt   = div_rem;
          state_nxt = S_RD_PICK;
        end
      end
      S_RD_PICK: begin
        state_nxt = S_RD_TAIL;
      end
      S_RD_TAIL: begin
        picked_nxt = written_r[idx_r] ? ram_rdata : idx_r;
        state_nxt  = S_WRITE;
      end
      S_WRITE: begin
        written_nxt[idx_r] = 1'b1;
        live_nxt      = live_r - CNT_W'(1);
        draws_nxt     = draws_inc;
        out_valid_nxt = 1'b1;
        drawn_nxt     = start_value_r + VALUE_W'(picked_r);
        left_nxt      = live_r - CNT_W'(1);
        err_nxt       = 1'b0;
        last_nxt      = (32'(draws_inc) == 32'(draw_count_r));
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      start_value_r <= VALUE_W'(1);
      pool_size_r   <= SIZE_W'(256);
      draw_count_r  <= SIZE_W'(256);
      live_r        <= POOL_FULL;
      draws_r       <= '0;
      written_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      draws_r     <= draws_nxt;
      written_r   <= written_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_START_VALUE: start_value_r <= cfg_wdata;
          REG_POOL_SIZE:   pool_size_r   <= cfg_wdata[SIZE_W-1:0];
          REG_DRAW_COUNT:  draw_count_r  <= cfg_wdata[SIZE_W-1:0];
          default: ;
        endcase
      end
    end
    idx_r    <= idx_nxt;
    picked_r <= picked_nxt;
    drawn_r  <= drawn_nxt;
    left_r   <= left_nxt;
    err_r    <= err_nxt;
    last_r   <= last_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_drawn_value = drawn_r;
  assign out_values_left = SIZE_W'(left_r);
  assign out_draw_error  = err_r;
  assign out_last_draw   = last_r;

endmodule

FILE: rtl/core/drd_chk.sv
// Port-level checker for distinct_random_draw_from_range, with its bind.
// Depends on drd_pkg.
module drd_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               in_cmd,
  input logic                               out_valid,
  input logic signed [drd_pkg::VALUE_W-1:0] out_drawn_value,
  input logic                               out_draw_error,
  input logic                               out_last_draw
);
  import drd_pkg::*;

  a_request_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("request neither answered nor in progress");

  a_result_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_restart_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd == CMD_RESTART)) |=>
      (out_valid && !out_draw_error && !out_last_draw && (out_drawn_value == '0)))
    else $error("bad restart result");

  a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_draw_error) |-> (!out_last_draw && (out_drawn_value == '0)))
    else $error("error result carries a value");

endmodule

bind distinct_random_draw_from_range drd_chk u_drd_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_cmd          (in_cmd),
  .out_valid       (out_valid),
  .out_drawn_value (out_drawn_value),
  .out_draw_error  (out_draw_error),
  .out_last_draw   (out_last_draw)
);
